// ===== hw/rtl/ric_pkg.sv =====
// ----------------------------------------------------------------------------
// ric_pkg
// Shared types, constants and constant tables of the rotary indexer cell
// tracker: command and motor codes, queue entry and result records, cell
// angle and modulo tables, front cell estimate.
// ----------------------------------------------------------------------------
package ric_pkg;

   // turntable geometry
   localparam int CELLS      = 5;
   localparam int CELL_IDX_W = $clog2(CELLS);

   // angles in centidegrees
   localparam int FULL_CD      = 36000;
   localparam int HALF_CD      = 18000;
   localparam int ALIGN_TOL_CD = 10;
   localparam int STEP_LIMIT   = 65535;

   // command queue between classifier and executor (power of two)
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // step count division by FULL_CD: shift by DIV_SHIFT, then reciprocal of DIV_ODD
   localparam int PROD_W      = 32;
   localparam int DIV_SHIFT   = 5;
   localparam int DIV_ODD     = FULL_CD >> DIV_SHIFT;
   localparam int X_W         = PROD_W - DIV_SHIFT;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 22;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_ODD);
   localparam int Q_W         = 17;

   // configuration registers
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_OFFSET = 2'd1;
   localparam logic [15:0] SPR_RESET    = 16'd3200;
   localparam logic [15:0] OFFSET_RESET = 16'd18000;

   localparam int FUNC_LAST = 9;

   typedef enum logic [3:0] {
      OP_ROTATE_BY      = 4'd0,
      OP_CELL_TO_FRONT  = 4'd1,
      OP_CELL_TO_SENSOR = 4'd2,
      OP_MOVE_DONE      = 4'd3,
      OP_RESET          = 4'd4,
      OP_ESTOP          = 4'd5,
      OP_OCCUPY_FRONT   = 4'd6,
      OP_CLEAR          = 4'd7,
      OP_SET_COLOR      = 4'd8,
      OP_READ           = 4'd9,
      OP_IGNORE         = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      MC_NONE  = 2'd0,
      MC_START = 2'd1,
      MC_RESET = 2'd2,
      MC_ESTOP = 2'd3
   } motor_cmd_type;

   typedef struct packed {
      op_type                 op;
      logic                   cell_ok;
      logic [CELL_IDX_W-1:0]  cell_idx;
      logic [16:0]            angle;
      logic [16:0]            target;
      logic [7:0]             color;
      logic [15:0]            period;
   } q_entry_type;

   typedef struct packed {
      logic          accepted;
      motor_cmd_type cmd;
      logic          neg;
      logic [16:0]   mag;
      logic [15:0]   period;
      logic          busy;
      logic [15:0]   angle_after;
      logic          occ;
      logic [7:0]    color;
      logic [15:0]   mask;
   } ex_res_type;

   typedef logic [CELL_IDX_W-1:0] cell_mod_tab_type [256];
   typedef logic [15:0]           cell_ang_tab_type [CELLS];
   typedef logic [15:0]           front_thr_tab_type [CELLS];

   function automatic cell_mod_tab_type build_cell_mod();
      cell_mod_tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = CELL_IDX_W'(i % CELLS);
      end
      return t;
   endfunction

   function automatic cell_ang_tab_type build_cell_ang();
      cell_ang_tab_type t;
      for (int n = 0; n < CELLS; n++) begin
         t[n] = 16'((n * FULL_CD) / CELLS);
      end
      return t;
   endfunction

   // entry k-1: smallest angle whose rounded cell index reaches k
   function automatic front_thr_tab_type build_front_thr();
      front_thr_tab_type t;
      for (int k = 1; k <= CELLS; k++) begin
         t[k-1] = 16'((k * FULL_CD - HALF_CD + CELLS - 1) / CELLS);
      end
      return t;
   endfunction

   localparam cell_mod_tab_type  CELL_MOD  = build_cell_mod();
   localparam cell_ang_tab_type  CELL_ANG  = build_cell_ang();
   localparam front_thr_tab_type FRONT_THR = build_front_thr();

   // nearest cell to the front opening, ties go to the next cell, wraps to 0
   function automatic logic [CELL_IDX_W-1:0] front_cell_of(input logic [15:0] a);
      logic [CELL_IDX_W:0] idx;
      idx = '0;
      for (int k = 1; k <= CELLS; k++) begin
         if (a >= FRONT_THR[k-1]) idx = (CELL_IDX_W+1)'(k);
      end
      if (idx == (CELL_IDX_W+1)'(CELLS)) idx = '0;
      return idx[CELL_IDX_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/ric_front.sv =====
// ----------------------------------------------------------------------------
// ric_front
// Request classifier: holds the configuration registers, decodes the
// function code and works out the target angle of cell moves.
// ----------------------------------------------------------------------------
module ric_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_func,
   input  logic [7:0]                     req_cell_req,
   input  logic signed [16:0]             req_angle_cd,
   input  logic [7:0]                     req_color_code,
   input  logic [15:0]                    req_step_period_us,
   input  logic                           csr_we,
   input  logic [ric_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_wdata,
   output logic                           q_valid,
   input  logic                           q_ready,
   output ric_pkg::q_entry_type           q_entry,
   output logic [15:0]                    steps_per_rev
);

   logic [15:0]                     spr_ff;
   logic [15:0]                     spr_in;
   logic [15:0]                     offset_ff;
   logic [15:0]                     offset_in;
   ric_pkg::op_type                 op;
   logic [ric_pkg::CELL_IDX_W-1:0]  cmod;
   logic [16:0]                     sensor_add;

   // offset is kept reduced below a full turn
   always_comb begin
      spr_in    = spr_ff;
      offset_in = offset_ff;
      if (csr_we) begin
         unique case (csr_index)
            ric_pkg::CSR_STEPS_PER_REV: spr_in = csr_wdata;
            ric_pkg::CSR_SENSOR_OFFSET: begin
               if (csr_wdata >= 16'(ric_pkg::FULL_CD)) begin
                  offset_in = csr_wdata - 16'(ric_pkg::FULL_CD);
               end else begin
                  offset_in = csr_wdata;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff    <= ric_pkg::SPR_RESET;
         offset_ff <= ric_pkg::OFFSET_RESET;
      end else begin
         spr_ff    <= spr_in;
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      if (req_func <= 4'(ric_pkg::FUNC_LAST)) begin
         op = ric_pkg::op_type'(req_func);
      end else begin
         op = ric_pkg::OP_IGNORE;
      end
      cmod       = ric_pkg::CELL_MOD[req_cell_req];
      sensor_add = (op == ric_pkg::OP_CELL_TO_SENSOR) ? {1'b0, offset_ff} : 17'd0;

      q_entry.op       = op;
      q_entry.cell_ok  = (req_cell_req < 8'(ric_pkg::CELLS));
      q_entry.cell_idx = cmod;
      q_entry.angle    = req_angle_cd;
      q_entry.target   = {1'b0, ric_pkg::CELL_ANG[cmod]} + sensor_add;
      q_entry.color    = req_color_code;
      q_entry.period   = req_step_period_us;
   end

   assign q_valid       = req_valid;
   assign req_ready     = q_ready;
   assign steps_per_rev = spr_ff;

endmodule

// ===== hw/rtl/ric_queue.sv =====
// ----------------------------------------------------------------------------
// ric_queue
// Short register queue of classified requests between classifier and
// executor.
// ----------------------------------------------------------------------------
module ric_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ric_pkg::q_entry_type  in_entry,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ric_pkg::q_entry_type  out_entry
);

   ric_pkg::q_entry_type          entries_ff [ric_pkg::QDEPTH];
   logic [ric_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [ric_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [ric_pkg::QPTR_W:0]      count_ff;
   logic [ric_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [ric_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [ric_pkg::QPTR_W:0]      count_in;
   logic                          push;
   logic                          pop;

   assign in_ready  = (count_ff != (ric_pkg::QPTR_W+1)'(ric_pkg::QDEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= in_entry;
   end

endmodule

// ===== hw/rtl/ric_exec.sv =====
// ----------------------------------------------------------------------------
// ric_exec
// Command executor: owns the tracked angle, move state, cell marks and colors,
// applies one request per cycle while advance is high, registers its result.
// ----------------------------------------------------------------------------
module ric_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  ric_pkg::q_entry_type  q_entry,
   input  logic                  advance,
   output logic                  ex_valid,
   output ric_pkg::ex_res_type   ex_res
);

   logic [15:0]          angle_ff;
   logic [15:0]          angle_in;
   logic                 moving_ff;
   logic                 moving_in;
   logic signed [16:0]   pending_ff;
   logic signed [16:0]   pending_in;
   logic                 marks_ff  [ric_pkg::CELLS];
   logic                 marks_in  [ric_pkg::CELLS];
   logic [7:0]           colors_ff [ric_pkg::CELLS];
   logic [7:0]           colors_in [ric_pkg::CELLS];
   logic                 ex_valid_ff;
   logic                 ex_valid_in;
   ric_pkg::ex_res_type  ex_res_ff;
   ric_pkg::ex_res_type  ex_res_in;

   logic                            pop;
   ric_pkg::op_type                 op;
   logic signed [17:0]              d_raw;
   logic signed [17:0]              d_norm;
   logic signed [16:0]              move;
   logic signed [17:0]              move_x;
   logic signed [17:0]              mag_x;
   logic                            is_rot;
   logic                            aligned;
   logic                            start;
   logic signed [18:0]              done_sum;
   logic signed [18:0]              done_red;
   logic [ric_pkg::CELL_IDX_W-1:0]  front_now;
   logic [15:0]                     mask_in;

   assign q_ready = advance;
   assign pop     = q_valid && advance;

   always_comb begin
      op        = q_entry.op;
      front_now = ric_pkg::front_cell_of(angle_ff);

      // shortest delta into (-half, half]
      d_raw = signed'({1'b0, q_entry.target}) - signed'({2'b00, angle_ff});
      if (d_raw > (ric_pkg::FULL_CD + ric_pkg::HALF_CD)) begin
         d_norm = 18'(d_raw - 2 * ric_pkg::FULL_CD);
      end else if (d_raw > ric_pkg::HALF_CD) begin
         d_norm = 18'(d_raw - ric_pkg::FULL_CD);
      end else if (d_raw <= -ric_pkg::HALF_CD) begin
         d_norm = 18'(d_raw + ric_pkg::FULL_CD);
      end else begin
         d_norm = d_raw;
      end

      is_rot  = (op == ric_pkg::OP_ROTATE_BY) || (op == ric_pkg::OP_CELL_TO_FRONT) ||
                (op == ric_pkg::OP_CELL_TO_SENSOR);
      aligned = (op != ric_pkg::OP_ROTATE_BY) && (d_norm > -ric_pkg::ALIGN_TOL_CD) &&
                (d_norm < ric_pkg::ALIGN_TOL_CD);
      move    = (op == ric_pkg::OP_ROTATE_BY) ? signed'(q_entry.angle) : d_norm[16:0];
      start   = is_rot && !moving_ff && !aligned;
      move_x  = 18'(move);
      mag_x   = (move_x < 0) ? -move_x : move_x;

      // angle after a completed move, wrapped into one turn
      done_sum = 19'(signed'({3'b000, angle_ff})) + 19'(pending_ff);
      if (done_sum < -ric_pkg::FULL_CD) begin
         done_red = 19'(done_sum + 2 * ric_pkg::FULL_CD);
      end else if (done_sum < 0) begin
         done_red = 19'(done_sum + ric_pkg::FULL_CD);
      end else if (done_sum < ric_pkg::FULL_CD) begin
         done_red = done_sum;
      end else if (done_sum < 2 * ric_pkg::FULL_CD) begin
         done_red = 19'(done_sum - ric_pkg::FULL_CD);
      end else begin
         done_red = 19'(done_sum - 2 * ric_pkg::FULL_CD);
      end

      angle_in   = angle_ff;
      moving_in  = moving_ff;
      pending_in = pending_ff;
      for (int i = 0; i < ric_pkg::CELLS; i++) begin
         marks_in[i]  = marks_ff[i];
         colors_in[i] = colors_ff[i];
      end

      ex_res_in.accepted = 1'b1;
      ex_res_in.cmd      = ric_pkg::MC_NONE;
      ex_res_in.neg      = 1'b0;
      ex_res_in.mag      = '0;
      ex_res_in.period   = '0;

      unique case (op) inside
         ric_pkg::OP_ROTATE_BY, ric_pkg::OP_CELL_TO_FRONT, ric_pkg::OP_CELL_TO_SENSOR: begin
            if (moving_ff) begin
               ex_res_in.accepted = 1'b0;
            end else if (start) begin
               pending_in       = move;
               moving_in        = 1'b1;
               ex_res_in.cmd    = ric_pkg::MC_START;
               ex_res_in.neg    = move_x < 0;
               ex_res_in.mag    = mag_x[16:0];
               ex_res_in.period = q_entry.period;
            end
         end
         ric_pkg::OP_MOVE_DONE: begin
            if (moving_ff) begin
               angle_in   = done_red[15:0];
               moving_in  = 1'b0;
               pending_in = '0;
            end
         end
         ric_pkg::OP_RESET: begin
            moving_in     = 1'b0;
            pending_in    = '0;
            ex_res_in.cmd = ric_pkg::MC_RESET;
         end
         ric_pkg::OP_ESTOP: begin
            moving_in     = 1'b0;
            pending_in    = '0;
            ex_res_in.cmd = ric_pkg::MC_ESTOP;
         end
         ric_pkg::OP_OCCUPY_FRONT: begin
            marks_in[front_now] = 1'b1;
         end
         ric_pkg::OP_CLEAR: begin
            if (q_entry.cell_ok) begin
               marks_in[q_entry.cell_idx]  = 1'b0;
               colors_in[q_entry.cell_idx] = '0;
            end
         end
         ric_pkg::OP_SET_COLOR: begin
            if (q_entry.cell_ok) colors_in[q_entry.cell_idx] = q_entry.color;
         end
         default: ;
      endcase

      mask_in = '0;
      for (int i = 0; i < ric_pkg::CELLS; i++) begin
         mask_in[i] = marks_in[i];
      end

      ex_res_in.busy        = moving_in;
      ex_res_in.angle_after = angle_in;
      ex_res_in.occ         = q_entry.cell_ok ? marks_in[q_entry.cell_idx] : 1'b0;
      ex_res_in.color       = q_entry.cell_ok ? colors_in[q_entry.cell_idx] : 8'd0;
      ex_res_in.mask        = mask_in;

      ex_valid_in = advance ? q_valid : ex_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff    <= '0;
         moving_ff   <= 1'b0;
         pending_ff  <= '0;
         ex_valid_ff <= 1'b0;
         for (int i = 0; i < ric_pkg::CELLS; i++) begin
            marks_ff[i]  <= 1'b0;
            colors_ff[i] <= '0;
         end
      end else begin
         ex_valid_ff <= ex_valid_in;
         if (pop) begin
            angle_ff   <= angle_in;
            moving_ff  <= moving_in;
            pending_ff <= pending_in;
            for (int i = 0; i < ric_pkg::CELLS; i++) begin
               marks_ff[i]  <= marks_in[i];
               colors_ff[i] <= colors_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) ex_res_ff <= ex_res_in;
   end

   assign ex_valid = ex_valid_ff;
   assign ex_res   = ex_res_ff;

endmodule

// ===== hw/rtl/ric_steps.sv =====
// ----------------------------------------------------------------------------
// ric_steps
// Step target pipeline and response register: angle times steps per
// revolution, reciprocal divide by a full turn, correction, saturation.
// ----------------------------------------------------------------------------
module ric_steps (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ex_valid,
   input  ric_pkg::ex_res_type  ex_res,
   input  logic [15:0]          steps_per_rev,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_accepted,
   output logic [1:0]           rsp_motor_command,
   output logic signed [16:0]   rsp_target_steps,
   output logic [15:0]          rsp_motor_period_us,
   output logic                 rsp_busy_res,
   output logic [3:0]           rsp_front_cell,
   output logic                 rsp_cell_occupied,
   output logic [7:0]           rsp_cell_color,
   output logic [15:0]          rsp_occupancy_mask
);

   // stage 2: product
   logic                              s2_valid_ff;
   ric_pkg::ex_res_type               s2_res_ff;
   logic [ric_pkg::PROD_W-1:0]        prod_ff;
   logic [ric_pkg::PROD_W:0]          prod_in;
   // stage 3: quotient estimate
   logic                              s3_valid_ff;
   ric_pkg::ex_res_type               s3_res_ff;
   logic [ric_pkg::X_W-1:0]           x_ff;
   logic [ric_pkg::X_W-1:0]           x_in;
   logic [ric_pkg::Q_W-1:0]           q0_ff;
   logic [ric_pkg::X_W+ric_pkg::RECIP_W-1:0] qm_in;
   // stage 4: response register
   logic                              rsp_valid_ff;
   logic                              accepted_ff;
   logic [1:0]                        cmd_ff;
   logic [16:0]                       steps_ff;
   logic [16:0]                       steps_in;
   logic [15:0]                       period_ff;
   logic                              busy_ff;
   logic [3:0]                        front_ff;
   logic                              occ_ff;
   logic [7:0]                        color_ff;
   logic [15:0]                       mask_ff;

   logic [ric_pkg::X_W:0]             back_in;
   logic [ric_pkg::X_W:0]             rem_in;
   logic [ric_pkg::Q_W:0]             q_fix;
   logic [15:0]                       sat;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      prod_in  = ex_res.mag * steps_per_rev;
      x_in     = prod_ff[ric_pkg::PROD_W-1:ric_pkg::DIV_SHIFT];
      qm_in    = x_in * ric_pkg::RECIP;
      back_in  = q0_ff * (ric_pkg::X_W+1)'(ric_pkg::DIV_ODD);
      rem_in   = {1'b0, x_ff} - back_in;
      // estimate is at most one low
      if (rem_in >= (ric_pkg::X_W+1)'(ric_pkg::DIV_ODD)) begin
         q_fix = (ric_pkg::Q_W+1)'(q0_ff) + (ric_pkg::Q_W+1)'(1);
      end else begin
         q_fix = (ric_pkg::Q_W+1)'(q0_ff);
      end
      sat      = (q_fix > (ric_pkg::Q_W+1)'(ric_pkg::STEP_LIMIT)) ?
                 16'(ric_pkg::STEP_LIMIT) : q_fix[15:0];
      steps_in = s3_res_ff.neg ? (17'd0 - {1'b0, sat}) : {1'b0, sat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= ex_valid;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_res_ff   <= ex_res;
         prod_ff     <= prod_in[ric_pkg::PROD_W-1:0];
         s3_res_ff   <= s2_res_ff;
         x_ff        <= x_in;
         q0_ff       <= qm_in[ric_pkg::RECIP_SHIFT +: ric_pkg::Q_W];
         accepted_ff <= s3_res_ff.accepted;
         cmd_ff      <= s3_res_ff.cmd;
         steps_ff    <= steps_in;
         period_ff   <= s3_res_ff.period;
         busy_ff     <= s3_res_ff.busy;
         front_ff    <= 4'(ric_pkg::front_cell_of(s3_res_ff.angle_after));
         occ_ff      <= s3_res_ff.occ;
         color_ff    <= s3_res_ff.color;
         mask_ff     <= s3_res_ff.mask;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = accepted_ff;
   assign rsp_motor_command   = cmd_ff;
   assign rsp_target_steps    = steps_ff;
   assign rsp_motor_period_us = period_ff;
   assign rsp_busy_res        = busy_ff;
   assign rsp_front_cell      = front_ff;
   assign rsp_cell_occupied   = occ_ff;
   assign rsp_cell_color      = color_ff;
   assign rsp_occupancy_mask  = mask_ff;

endmodule

// ===== hw/rtl/rotary_indexer_cell_tracker.sv =====
// ----------------------------------------------------------------------------
// rotary_indexer_cell_tracker
// Turntable position and cell bookkeeping: turns requests into motor move
// commands and keeps per-cell occupied marks and color codes.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_ready is high and returns exactly one
// response per request, in order. A request accepted into the request queue
// passes to the executor, which applies the request to the tracked angle,
// move state and cell store, and then through the step pipeline (angle times
// steps_per_rev, then a reciprocal divide by a full turn with a one-step
// correction) into the response register. The executor is the only stage
// that reads and writes the block state, and it completes a request every
// cycle unless a stalled response holds it, so back-to-back requests see
// each other's effects in order. A stalled response holds the whole back end;
// the four-deep request queue keeps req_ready high until it fills. Angles are
// in centidegrees modulo 36000; cell moves take the shortest path and a
// rotation command is refused (accepted low) while a move waits for its done
// event. Configuration writes take effect on the next cycle and are meant to be
// made while no request is in flight.
// ----------------------------------------------------------------------------
module rotary_indexer_cell_tracker (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_func,
   input  logic [7:0]                     req_cell_req,
   input  logic signed [16:0]             req_angle_cd,
   input  logic [7:0]                     req_color_code,
   input  logic [15:0]                    req_step_period_us,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic [1:0]                     rsp_motor_command,
   output logic signed [16:0]             rsp_target_steps,
   output logic [15:0]                    rsp_motor_period_us,
   output logic                           rsp_busy_res,
   output logic [3:0]                     rsp_front_cell,
   output logic                           rsp_cell_occupied,
   output logic [7:0]                     rsp_cell_color,
   output logic [15:0]                    rsp_occupancy_mask,
   // configuration write port
   input  logic                           csr_we,
   input  logic [ric_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_wdata
);

   // classifier to queue
   logic                  fq_valid;
   logic                  fq_ready;
   ric_pkg::q_entry_type  fq_entry;
   // queue to executor
   logic                  qe_valid;
   logic                  qe_ready;
   ric_pkg::q_entry_type  qe_entry;
   // executor to step pipeline
   logic                  ex_valid;
   ric_pkg::ex_res_type   ex_res;
   logic                  advance;
   logic [15:0]           steps_per_rev;

   // decode, target angle of cell moves, configuration registers
   ric_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_cell_req       (req_cell_req),
      .req_angle_cd       (req_angle_cd),
      .req_color_code     (req_color_code),
      .req_step_period_us (req_step_period_us),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_valid            (fq_valid),
      .q_ready            (fq_ready),
      .q_entry            (fq_entry),
      .steps_per_rev      (steps_per_rev)
   );

   // decouples the request side from response stalls
   ric_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qe_valid),
      .out_ready (qe_ready),
      .out_entry (qe_entry)
   );

   // state owner: angle, move in progress, marks and colors
   ric_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (qe_valid),
      .q_ready  (qe_ready),
      .q_entry  (qe_entry),
      .advance  (advance),
      .ex_valid (ex_valid),
      .ex_res   (ex_res)
   );

   // step target arithmetic and response register
   ric_steps u_steps (
      .clock               (clock),
      .reset               (reset),
      .ex_valid            (ex_valid),
      .ex_res              (ex_res),
      .steps_per_rev       (steps_per_rev),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_motor_command   (rsp_motor_command),
      .rsp_target_steps    (rsp_target_steps),
      .rsp_motor_period_us (rsp_motor_period_us),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_front_cell      (rsp_front_cell),
      .rsp_cell_occupied   (rsp_cell_occupied),
      .rsp_cell_color      (rsp_cell_color),
      .rsp_occupancy_mask  (rsp_occupancy_mask)
   );

endmodule

// ===== hw/rtl/ric_checker.sv =====
// ----------------------------------------------------------------------------
// ric_checker
// Port-level checks of the rotary indexer cell tracker responses, bound to
// the top level.
// ----------------------------------------------------------------------------
module ric_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [3:0]                     req_func,
   input  logic [7:0]                     req_cell_req,
   input  logic signed [16:0]             req_angle_cd,
   input  logic [7:0]                     req_color_code,
   input  logic [15:0]                    req_step_period_us,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_accepted,
   input  logic [1:0]                     rsp_motor_command,
   input  logic signed [16:0]             rsp_target_steps,
   input  logic [15:0]                    rsp_motor_period_us,
   input  logic                           rsp_busy_res,
   input  logic [3:0]                     rsp_front_cell,
   input  logic                           rsp_cell_occupied,
   input  logic [7:0]                     rsp_cell_color,
   input  logic [15:0]                    rsp_occupancy_mask,
   input  logic                           csr_we,
   input  logic [ric_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_wdata
);

   // a started move leaves the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_command == ric_pkg::MC_START |-> rsp_accepted && rsp_busy_res)
      else $error("start move without busy");

   // step target and period only travel with a start move
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_command != ric_pkg::MC_START
      |-> rsp_target_steps == 17'sd0 && rsp_motor_period_us == 16'd0)
      else $error("step fields set without start move");

   // refusal only happens while busy and issues nothing
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_busy_res && rsp_motor_command == ric_pkg::MC_NONE)
      else $error("refused request not busy or with command");

   // reset and estop end any move
   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_motor_command == ric_pkg::MC_RESET ||
                    rsp_motor_command == ric_pkg::MC_ESTOP) |-> !rsp_busy_res)
      else $error("busy after reset or estop");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_motor_command) &&
      $stable(rsp_target_steps) && $stable(rsp_occupancy_mask))
      else $error("stalled response changed");

endmodule

bind rotary_indexer_cell_tracker ric_checker u_ric_checker (.*);

// ===== tb/sv/rotary_indexer_cell_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// rotary_indexer_cell_tracker_tb
// Self-checking bench for the turntable cell tracker. A short table of
// directed requests comes first, then four random request streams, each under
// its own register setting and handshake pressure. A built-in model of the
// turntable predicts every response, and responses are checked field by
// field in order.
// ----------------------------------------------------------------------------
module rotary_indexer_cell_tracker_tb;
   import ric_pkg::*;

   localparam int DIRECTED_ROWS  = 27;
   localparam int PHASE_ITEMS    = 256;
   localparam int STAGES         = 4;
   localparam int SETTLE_CYCLES  = 8;     // margin past the response pipeline
   localparam int WATCHDOG_LIMIT = 2000;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [3:0]         func;
      logic [7:0]         slot;
      logic signed [16:0] angle;
      logic [7:0]         color;
      logic [15:0]        period;
   } turn_request_t;

   typedef struct packed {
      logic               accepted;
      motor_cmd_type      cmd;
      logic signed [16:0] steps;
      logic [15:0]        period;
      logic               busy;
      logic [3:0]         front;
      logic               occ;
      logic [7:0]         color;
      logic [15:0]        mask;
   } turn_result_t;

   // has_want set: the response is typed into the row, not taken from the model
   typedef struct packed {
      logic          has_want;
      turn_request_t req;
      turn_result_t  want;
   } directed_row_t;

   // accepted, nothing started, idle table at angle 0, empty out-of-range cell
   localparam turn_result_t QUIET_RESULT =
      '{1'b1, MC_NONE, 17'sd0, 16'd0, 1'b0, 4'd0, 1'b0, 8'd0, 16'd0};

   // ---------------------------------------------------------------------
   // clock, reset and block ports
   // ---------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_valid          = 1'b0;
   logic                    req_ready;
   logic [3:0]              req_func           = '0;
   logic [7:0]              req_cell_req       = '0;
   logic signed [16:0]      req_angle_cd       = '0;
   logic [7:0]              req_color_code     = '0;
   logic [15:0]             req_step_period_us = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_accepted;
   logic [1:0]              rsp_motor_command;
   logic signed [16:0]      rsp_target_steps;
   logic [15:0]             rsp_motor_period_us;
   logic                    rsp_busy_res;
   logic [3:0]              rsp_front_cell;
   logic                    rsp_cell_occupied;
   logic [7:0]              rsp_cell_color;
   logic [15:0]             rsp_occupancy_mask;

   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [15:0]             csr_wdata = '0;

   always #6 clock = ~clock;

   rotary_indexer_cell_tracker dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_cell_req        (req_cell_req),
      .req_angle_cd        (req_angle_cd),
      .req_color_code      (req_color_code),
      .req_step_period_us  (req_step_period_us),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_motor_command   (rsp_motor_command),
      .rsp_target_steps    (rsp_target_steps),
      .rsp_motor_period_us (rsp_motor_period_us),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_front_cell      (rsp_front_cell),
      .rsp_cell_occupied   (rsp_cell_occupied),
      .rsp_cell_color      (rsp_cell_color),
      .rsp_occupancy_mask  (rsp_occupancy_mask),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // turntable model state, kept in step with every accepted request
   // ---------------------------------------------------------------------
   int            table_angle_cd  = 0;      // tracked angle, 0..35999
   bit            table_moving    = 1'b0;
   int            pending_turn_cd = 0;      // angle added on the done event
   bit            cell_marked [CELLS];
   bit [7:0]      cell_paint  [CELLS];
   int            steps_per_rev_q = SPR_RESET;
   int            sensor_offset_q = OFFSET_RESET;

   turn_result_t  owed_results [$];          // responses still to come, oldest first
   directed_row_t directed_rows [DIRECTED_ROWS];
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;
   int            req_idle_pct   = 0;
   int            rsp_stall_pct  = 0;

   // nearest cell to the opening, ties rounded up, wrapping back to cell 0
   function automatic int front_cell_now();
      return int'((longint'(table_angle_cd) * CELLS + HALF_CD) / FULL_CD) % CELLS;
   endfunction

   // apply one request to the turntable model and return its response
   function automatic turn_result_t advance_turntable(input turn_request_t r);
      turn_result_t res;
      int           move_cd;
      int           aim_cd;
      int           wrapped;
      longint       steps;
      bit           needs_move;
      res = QUIET_RESULT;
      case (r.func) inside
         OP_ROTATE_BY, OP_CELL_TO_FRONT, OP_CELL_TO_SENSOR: begin
            if (table_moving) begin
               // rotation refused while a move waits for its done event
               res.accepted = 1'b0;
            end else begin
               move_cd    = r.angle;
               needs_move = 1'b1;
               if (r.func != OP_ROTATE_BY) begin
                  aim_cd = ((int'(r.slot) % CELLS) * FULL_CD) / CELLS;
                  if (r.func == OP_CELL_TO_SENSOR) aim_cd += sensor_offset_q % FULL_CD;
                  // shortest path, half turn kept positive
                  move_cd = aim_cd - table_angle_cd;
                  while (move_cd > HALF_CD) move_cd -= FULL_CD;
                  while (move_cd <= -HALF_CD) move_cd += FULL_CD;
                  needs_move = (move_cd <= -ALIGN_TOL_CD) || (move_cd >= ALIGN_TOL_CD);
               end
               if (needs_move) begin
                  steps = (longint'(move_cd) * steps_per_rev_q) / FULL_CD;
                  if (steps > STEP_LIMIT) steps = STEP_LIMIT;
                  if (steps < -STEP_LIMIT) steps = -STEP_LIMIT;
                  pending_turn_cd = move_cd;
                  table_moving    = 1'b1;
                  res.cmd         = MC_START;
                  res.steps       = 17'(steps);
                  res.period      = r.period;
               end
            end
         end
         OP_MOVE_DONE: begin
            // a done event with no move running is dropped
            if (table_moving) begin
               wrapped = (table_angle_cd + pending_turn_cd) % FULL_CD;
               if (wrapped < 0) wrapped += FULL_CD;
               table_angle_cd  = wrapped;
               table_moving    = 1'b0;
               pending_turn_cd = 0;
            end
         end
         OP_RESET, OP_ESTOP: begin
            table_moving    = 1'b0;
            pending_turn_cd = 0;
            res.cmd         = (r.func == OP_RESET) ? MC_RESET : MC_ESTOP;
         end
         OP_OCCUPY_FRONT: cell_marked[front_cell_now()] = 1'b1;
         OP_CLEAR: begin
            if (r.slot < CELLS) begin
               cell_marked[r.slot] = 1'b0;
               cell_paint[r.slot]  = '0;
            end
         end
         OP_SET_COLOR: begin
            if (r.slot < CELLS) cell_paint[r.slot] = r.color;
         end
         default: ;  // unused codes change nothing
      endcase
      res.busy  = table_moving;
      res.front = 4'(front_cell_now());
      if (r.slot < CELLS) begin
         res.occ   = cell_marked[r.slot];
         res.color = cell_paint[r.slot];
      end
      for (int n = 0; n < CELLS; n++) res.mask[n] = cell_marked[n];
      return res;
   endfunction

   // random request; a running move is mostly followed by its done event
   function automatic turn_request_t random_request();
      turn_request_t r;
      int            roll;
      int            pick;
      r.slot   = ($urandom_range(99) < 75) ? 8'($urandom_range(CELLS - 1))
                                           : 8'($urandom_range(255));
      r.color  = 8'($urandom);
      r.period = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 10) begin
         case ($urandom_range(4))
            0:       pick = -FULL_CD;
            1:       pick = FULL_CD;
            2:       pick = -HALF_CD;
            3:       pick = HALF_CD;
            default: pick = 0;
         endcase
      end else if (roll < 35) begin
         pick = int'($urandom_range(40)) - 20;
      end else begin
         pick = int'($urandom_range(2 * FULL_CD)) - FULL_CD;
      end
      r.angle = 17'(pick);
      roll = $urandom_range(99);
      if (table_moving && $urandom_range(99) < 50) r.func = OP_MOVE_DONE;
      else if (roll < 14) r.func = OP_ROTATE_BY;
      else if (roll < 26) r.func = OP_CELL_TO_FRONT;
      else if (roll < 36) r.func = OP_CELL_TO_SENSOR;
      else if (roll < 56) r.func = OP_MOVE_DONE;
      else if (roll < 59) r.func = OP_RESET;
      else if (roll < 62) r.func = OP_ESTOP;
      else if (roll < 72) r.func = OP_OCCUPY_FRONT;
      else if (roll < 80) r.func = OP_CLEAR;
      else if (roll < 89) r.func = OP_SET_COLOR;
      else if (roll < 97) r.func = OP_READ;
      else                r.func = 4'($urandom_range(15, FUNC_LAST + 1));
      return r;
   endfunction

   // present one request, hold it until taken, then log what it should return
   task automatic send_request(input turn_request_t r, input logic has_want,
                               input turn_result_t want);
      turn_result_t predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= r.func;
      req_cell_req       <= r.slot;
      req_angle_cd       <= r.angle;
      req_color_code     <= r.color;
      req_step_period_us <= r.period;
      do @(posedge clock); while (!req_ready);
      predicted = advance_turntable(r);
      owed_results.push_back(has_want ? want : predicted);
   endtask

   // one register write; the caller drops csr_we after the last one
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_STEPS_PER_REV) steps_per_rev_q = data;
      else if (idx == CSR_SENSOR_OFFSET) sensor_offset_q = data;
   endtask

   // stop sending and let every outstanding response come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver: random backpressure at the current stall rate
   // ---------------------------------------------------------------------
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // ---------------------------------------------------------------------
   // response checker: each response against the oldest owed one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      turn_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_results.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            mismatch_count++;
         end else begin
            want = owed_results.pop_front();
            compare_field("accepted",        want.accepted, rsp_accepted);
            compare_field("motor_command",   want.cmd,      rsp_motor_command);
            compare_field("target_steps",    want.steps,    rsp_target_steps);
            compare_field("motor_period_us", want.period,   rsp_motor_period_us);
            compare_field("busy_res",        want.busy,     rsp_busy_res);
            compare_field("front_cell",      want.front,    rsp_front_cell);
            compare_field("cell_occupied",   want.occ,      rsp_cell_occupied);
            compare_field("cell_color",      want.color,    rsp_cell_color);
            compare_field("occupancy_mask",  want.mask,     rsp_occupancy_mask);
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long with no request and no response taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [15:0] spr_pick;
      logic [15:0] offset_pick;

      // reset values: 3200 steps per turn, sensor half a turn from the opening
      directed_rows = '{
         // idle table reads back empty, in range and out of range
         '{1'b1, '{OP_READ,           8'd0,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         '{1'b1, '{OP_READ,           8'd255, 17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         // done event with no move running
         '{1'b1, '{OP_MOVE_DONE,      8'd0,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         // unused code
         '{1'b1, '{OP_IGNORE,         8'd0,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         // bad cell index on set and clear, then a valid color and a front mark
         '{1'b1, '{OP_SET_COLOR,      8'd5,   17'sd0,     8'd255, 16'd0},     QUIET_RESULT},
         '{1'b1, '{OP_CLEAR,          8'd255, 17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         '{1'b1, '{OP_SET_COLOR,      8'd4,   17'sd0,     8'd255, 16'd0},
               '{1'b1, MC_NONE, 17'sd0, 16'd0, 1'b0, 4'd0, 1'b0, 8'd255, 16'h0000}},
         '{1'b1, '{OP_OCCUPY_FRONT,   8'd0,   17'sd0,     8'd0,   16'd0},
               '{1'b1, MC_NONE, 17'sd0, 16'd0, 1'b0, 4'd0, 1'b1, 8'd0, 16'h0001}},
         // full turn forward, then a rotation refused while busy
         '{1'b1, '{OP_ROTATE_BY,      8'd0,   17'sd36000, 8'd0,   16'hFFFF},
               '{1'b1, MC_START, 17'sd3200, 16'hFFFF, 1'b1, 4'd0, 1'b1, 8'd0, 16'h0001}},
         '{1'b1, '{OP_ROTATE_BY,      8'd4,   -17'sd36000, 8'd0,  16'd0},
               '{1'b0, MC_NONE, 17'sd0, 16'd0, 1'b1, 4'd0, 1'b0, 8'd255, 16'h0001}},
         '{1'b0, '{OP_CELL_TO_SENSOR, 8'd1,   17'sd0,     8'd0,   16'd7},     QUIET_RESULT},
         '{1'b0, '{OP_MOVE_DONE,      8'd0,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         // full turn back, cut short by an emergency stop
         '{1'b0, '{OP_ROTATE_BY,      8'd0,   -17'sd36000, 8'd0,  16'd1},     QUIET_RESULT},
         '{1'b1, '{OP_ESTOP,          8'd0,   17'sd0,     8'd0,   16'd0},
               '{1'b1, MC_ESTOP, 17'sd0, 16'd0, 1'b0, 4'd0, 1'b1, 8'd0, 16'h0001}},
         // zero rotation still starts a move, then a motor reset drops it
         '{1'b0, '{OP_ROTATE_BY,      8'd0,   17'sd0,     8'd0,   16'd100},   QUIET_RESULT},
         '{1'b1, '{OP_RESET,          8'd0,   17'sd0,     8'd0,   16'd0},
               '{1'b1, MC_RESET, 17'sd0, 16'd0, 1'b0, 4'd0, 1'b1, 8'd0, 16'h0001}},
         // cell index folded modulo the cell count, then already aligned
         '{1'b0, '{OP_CELL_TO_FRONT,  8'd7,   17'sd0,     8'd0,   16'd500},   QUIET_RESULT},
         '{1'b0, '{OP_MOVE_DONE,      8'd2,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         '{1'b0, '{OP_CELL_TO_FRONT,  8'd2,   17'sd0,     8'd0,   16'd500},   QUIET_RESULT},
         // nudge inside the alignment window
         '{1'b0, '{OP_ROTATE_BY,      8'd2,   17'sd9,     8'd0,   16'd3},     QUIET_RESULT},
         '{1'b0, '{OP_MOVE_DONE,      8'd2,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         '{1'b0, '{OP_CELL_TO_FRONT,  8'd2,   17'sd0,     8'd0,   16'd3},     QUIET_RESULT},
         // land exactly between cells 0 and 1: front rounds up
         '{1'b0, '{OP_ROTATE_BY,      8'd1,   -17'sd10809, 8'd0,  16'd9},     QUIET_RESULT},
         '{1'b0, '{OP_MOVE_DONE,      8'd1,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         // exactly half a turn away stays a positive move
         '{1'b0, '{OP_CELL_TO_FRONT,  8'd3,   17'sd0,     8'd0,   16'd40},    QUIET_RESULT},
         '{1'b0, '{OP_MOVE_DONE,      8'd3,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT},
         '{1'b0, '{OP_CLEAR,          8'd0,   17'sd0,     8'd0,   16'd0},     QUIET_RESULT}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].has_want, directed_rows[i].want);
      end

      // random streams, each under a fresh register setting and pressure
      for (int stage = 0; stage < STAGES; stage++) begin
         wait_drained();
         case (stage)
            0: begin
               spr_pick = 16'd1;
               offset_pick = 16'd0;
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               spr_pick = 16'hFFFF;
               offset_pick = 16'(FULL_CD - 1);
               req_idle_pct = 48;
               rsp_stall_pct = 0;
            end
            2: begin
               // offset above a full turn, reduced before use
               spr_pick = 16'($urandom_range(65535, 1));
               offset_pick = 16'hFFFF;
               req_idle_pct = 0;
               rsp_stall_pct = 48;
            end
            default: begin
               spr_pick = SPR_RESET;
               offset_pick = 16'($urandom_range(FULL_CD - 1));
               req_idle_pct = 25;
               rsp_stall_pct = 25;
            end
         endcase
         // writes to the spare indexes must not disturb either register
         write_register(CSR_STEPS_PER_REV, spr_pick);
         write_register(CSR_SPARE_LO, 16'($urandom));
         write_register(CSR_SENSOR_OFFSET, offset_pick);
         write_register(CSR_SPARE_HI, 16'($urandom));
         csr_we <= 1'b0;
         repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, QUIET_RESULT);
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ric_pkg.sv
hw/rtl/ric_front.sv
hw/rtl/ric_queue.sv
hw/rtl/ric_exec.sv
hw/rtl/ric_steps.sv
hw/rtl/rotary_indexer_cell_tracker.sv
hw/rtl/ric_checker.sv
tb/sv/rotary_indexer_cell_tracker_tb.sv
